// ===== src/ima_pkg.sv =====
// Shared types, constants and tables for the IMU mount alignment block.
// Used by the CORDIC, the coefficient builder,
// the sample datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package ima_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int FIELD_W = 16;
  localparam int COEF_W  = 18;
  localparam int IDX_W   = 3;
  localparam int NCOEF   = 9;

  localparam logic signed [17:0] ANG_HALF    = 18'sd23040;
  localparam logic signed [17:0] ANG_TURN    = 18'sd46080;
  localparam logic signed [17:0] ANG_QUARTER = 18'sd11520;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd65536;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [IDX_W-1:0] {
    REG_YAW     = 3'd0,
    REG_PITCH   = 3'd1,
    REG_ROLL    = 3'd2,
    REG_SCALE_X = 3'd3,
    REG_SCALE_Y = 3'd4,
    REG_SCALE_Z = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_CY, OP_SY, OP_CP, OP_SP, OP_CR, OP_SR, OP_ONE, OP_ZERO
  } op_sel_t;

  typedef struct packed {
    op_sel_t a;
    op_sel_t b;
    op_sel_t c;
    logic    neg;
  } term_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] gyro_x_in;
    logic signed [FIELD_W-1:0] gyro_y_in;
    logic signed [FIELD_W-1:0] gyro_z_in;
    logic signed [FIELD_W-1:0] accel_x_in;
    logic signed [FIELD_W-1:0] accel_y_in;
    logic signed [FIELD_W-1:0] accel_z_in;
  } sample_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] gyro_x_out;
    logic signed [FIELD_W-1:0] gyro_y_out;
    logic signed [FIELD_W-1:0] gyro_z_out;
    logic signed [FIELD_W-1:0] accel_x_out;
    logic signed [FIELD_W-1:0] accel_y_out;
    logic signed [FIELD_W-1:0] accel_z_out;
  } sample_out_t;

  typedef struct packed {
    logic [IDX_W-1:0]   addr;
    logic [FIELD_W-1:0] wdata;
  } cfg_word_t;

  typedef struct packed {
    logic               start;
    logic signed [15:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [COEF_W-1:0] cos_v;
    logic signed [COEF_W-1:0] sin_v;
  } cordic_resp_t;

  // arctan(2^-i) in units of 2^-23 degree
  function automatic logic [28:0] cordic_atan(input logic [4:0] i);
    logic [28:0] r;
    case (i)
      5'd0:  r = 29'd377487360;
      5'd1:  r = 29'd222843801;
      5'd2:  r = 29'd117744544;
      5'd3:  r = 29'd59768969;
      5'd4:  r = 29'd30000467;
      5'd5:  r = 29'd15014858;
      5'd6:  r = 29'd7509261;
      5'd7:  r = 29'd3754860;
      5'd8:  r = 29'd1877459;
      5'd9:  r = 29'd938733;
      5'd10: r = 29'd469367;
      5'd11: r = 29'd234683;
      5'd12: r = 29'd117342;
      5'd13: r = 29'd58671;
      5'd14: r = 29'd29335;
      5'd15: r = 29'd14668;
      5'd16: r = 29'd7334;
      5'd17: r = 29'd3667;
      5'd18: r = 29'd1833;
      5'd19: r = 29'd917;
      5'd20: r = 29'd458;
      5'd21: r = 29'd229;
      5'd22: r = 29'd115;
      5'd23: r = 29'd57;
      default: r = 29'd0;
    endcase
    return r;
  endfunction

  // Each coefficient is +-a*b*c +- a*b*c; a unit factor stands for the 2^16 scale.
  function automatic term_t coef_term(input logic [3:0] ci, input logic tsel);
    term_t t;
    t = '{OP_ZERO, OP_ZERO, OP_ZERO, 1'b0};
    case ({ci, tsel})
      {4'd0, 1'b0}: t = '{OP_CY, OP_CR, OP_ONE, 1'b0};
      {4'd0, 1'b1}: t = '{OP_SY, OP_SP, OP_SR,  1'b0};
      {4'd1, 1'b0}: t = '{OP_CP, OP_SY, OP_ONE, 1'b0};
      {4'd2, 1'b0}: t = '{OP_CY, OP_SR, OP_ONE, 1'b0};
      {4'd2, 1'b1}: t = '{OP_CR, OP_SY, OP_SP,  1'b1};
      {4'd3, 1'b0}: t = '{OP_CY, OP_SP, OP_SR,  1'b0};
      {4'd3, 1'b1}: t = '{OP_CR, OP_SY, OP_ONE, 1'b1};
      {4'd4, 1'b0}: t = '{OP_CY, OP_CP, OP_ONE, 1'b0};
      {4'd5, 1'b0}: t = '{OP_SY, OP_SR, OP_ONE, 1'b1};
      {4'd5, 1'b1}: t = '{OP_CY, OP_CR, OP_SP,  1'b1};
      {4'd6, 1'b0}: t = '{OP_CP, OP_SR, OP_ONE, 1'b1};
      {4'd7, 1'b0}: t = '{OP_SP, OP_ONE, OP_ONE, 1'b0};
      {4'd8, 1'b0}: t = '{OP_CP, OP_CR, OP_ONE, 1'b0};
      default:      t = '{OP_ZERO, OP_ZERO, OP_ZERO, 1'b0};
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== src/ima_chan_if.sv =====
// Valid/ready channel carrying one payload word.
// Payload type comes from ima_pkg at the point of instantiation.
`timescale 1ns / 1ps
`default_nettype none
interface ima_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/ima_cordic.sv =====
// Iterative rotation-mode CORDIC: sine and cosine of a mount angle in Q1.16.
// Depends on ima_pkg for the arctan table and request/response structs.
`timescale 1ns / 1ps
`default_nettype none
module ima_cordic import ima_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cordic_req_t  req,
  output cordic_resp_t resp
);

  localparam int CW = $clog2(CORDIC_STEPS);
  localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cstate_t;

  cstate_t            state;
  logic signed [33:0] x, y, z;
  logic               flip;
  logic [CW-1:0]      cnt;

  logic signed [17:0] a0, a1, a2;
  logic               f_in;
  logic signed [33:0] xs, ys, at, xr, yr;
  logic signed [COEF_W-1:0] xc, yc;

  // wrap into [-180,180), then fold into [-90,90]
  always_comb begin
    a0 = 18'(req.angle);
    if (a0 >= ANG_HALF) a1 = a0 - ANG_TURN;
    else if (a0 < -ANG_HALF) a1 = a0 + ANG_TURN;
    else a1 = a0;
    f_in = 1'b1;
    if (a1 > ANG_QUARTER) a2 = a1 - ANG_HALF;
    else if (a1 < -ANG_QUARTER) a2 = a1 + ANG_HALF;
    else begin
      a2   = a1;
      f_in = 1'b0;
    end
  end

  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = $signed({5'd0, cordic_atan(5'(cnt))});
    xr = (x + 34'sd8192) >>> 14;
    yr = (y + 34'sd8192) >>> 14;
    if (xr > 34'sd65536) xc = COEF_ONE;
    else if (xr < -34'sd65536) xc = -COEF_ONE;
    else xc = COEF_W'(xr);
    if (yr > 34'sd65536) yc = COEF_ONE;
    else if (yr < -34'sd65536) yc = -COEF_ONE;
    else yc = COEF_W'(yr);
  end

  assign resp.done  = (state == C_DONE);
  assign resp.cos_v = flip ? -xc : xc;
  assign resp.sin_v = flip ? -yc : yc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
    end else if (req.start) begin
      state <= C_RUN;
      cnt   <= '0;
      x     <= CORDIC_GAIN;
      y     <= '0;
      z     <= $signed({a2, 16'd0});
      flip  <= f_in;
    end else begin
      case (state)
        C_RUN: begin
          if (!z[33]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          if (cnt == LAST) state <= C_DONE;
          else cnt <= cnt + 1'b1;
        end
        C_DONE:  state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/ima_coef_build.sv =====
// Rotation matrix builder: three CORDIC runs, then each coefficient as a sum
// of triple products on a shift-add multiplier. Depends on ima_pkg, ima_cordic.
`timescale 1ns / 1ps
`default_nettype none
module ima_coef_build import ima_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rebuild,
  input  logic signed [15:0] yaw,
  input  logic signed [15:0] pitch,
  input  logic signed [15:0] roll,
  output logic               busy,
  output coef_t              coef [NCOEF]
);

  localparam logic [4:0] MUL_LAST = 5'd17;
  localparam logic [3:0] CI_LAST  = 4'(NCOEF - 1);

  typedef enum logic [2:0] {
    B_IDLE, B_ANG, B_ANG_WAIT, B_LOAD1, B_MUL1, B_LOAD2, B_MUL2, B_ACC
  } bstate_t;

  bstate_t            state;
  logic [1:0]         ang_sel;
  coef_t              cy, sy, cp, sp, cr, sr;
  logic [3:0]         ci;
  logic               tsel;
  logic signed [53:0] acc, mcand, prod;
  logic [17:0]        mplier;
  logic [4:0]         mcnt;

  cordic_req_t  creq;
  cordic_resp_t cres;
  term_t        tm;
  coef_t        op_a, op_b, op_c;
  logic signed [53:0] prod_step, acc_sum, rnd;
  coef_t        coef_new;

  function automatic coef_t pick(input op_sel_t s, input coef_t vcy, input coef_t vsy,
                                 input coef_t vcp, input coef_t vsp, input coef_t vcr,
                                 input coef_t vsr);
    coef_t r;
    case (s)
      OP_CY:   r = vcy;
      OP_SY:   r = vsy;
      OP_CP:   r = vcp;
      OP_SP:   r = vsp;
      OP_CR:   r = vcr;
      OP_SR:   r = vsr;
      OP_ONE:  r = COEF_ONE;
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    creq.start = (state == B_ANG);
    case (ang_sel)
      2'd0:    creq.angle = yaw;
      2'd1:    creq.angle = pitch;
      default: creq.angle = roll;
    endcase
  end

  ima_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .req  (creq),
    .resp (cres)
  );

  always_comb begin
    tm   = coef_term(ci, tsel);
    op_a = pick(tm.a, cy, sy, cp, sp, cr, sr);
    op_b = pick(tm.b, cy, sy, cp, sp, cr, sr);
    op_c = pick(tm.c, cy, sy, cp, sp, cr, sr);
    // the top multiplier bit carries negative weight
    if (!mplier[0]) prod_step = prod;
    else if (mcnt == MUL_LAST) prod_step = prod - mcand;
    else prod_step = prod + mcand;
    acc_sum = tm.neg ? acc - prod : acc + prod;
    rnd = (acc_sum + 54'sd2147483648) >>> 32;
    if (rnd > 54'sd65536) coef_new = COEF_ONE;
    else if (rnd < -54'sd65536) coef_new = -COEF_ONE;
    else coef_new = COEF_W'(rnd);
  end

  assign busy = (state != B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_ANG;
      ang_sel <= 2'd0;
      ci      <= '0;
      tsel    <= 1'b0;
      mcnt    <= '0;
    end else if (rebuild) begin
      state   <= B_ANG;
      ang_sel <= 2'd0;
    end else begin
      case (state)
        B_ANG: state <= B_ANG_WAIT;
        B_ANG_WAIT: begin
          if (cres.done) begin
            case (ang_sel)
              2'd0: begin
                cy <= cres.cos_v;
                sy <= cres.sin_v;
              end
              2'd1: begin
                cp <= cres.cos_v;
                sp <= cres.sin_v;
              end
              default: begin
                cr <= cres.cos_v;
                sr <= cres.sin_v;
              end
            endcase
            if (ang_sel == 2'd2) begin
              ci    <= '0;
              tsel  <= 1'b0;
              acc   <= '0;
              state <= B_LOAD1;
            end else begin
              ang_sel <= ang_sel + 1'b1;
              state   <= B_ANG;
            end
          end
        end
        B_LOAD1: begin
          mcand  <= 54'(op_a);
          mplier <= op_b;
          prod   <= '0;
          mcnt   <= '0;
          state  <= B_MUL1;
        end
        B_MUL1, B_MUL2: begin
          prod   <= prod_step;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          mcnt   <= mcnt + 1'b1;
          if (mcnt == MUL_LAST) state <= (state == B_MUL1) ? B_LOAD2 : B_ACC;
        end
        B_LOAD2: begin
          mcand  <= prod;
          mplier <= op_c;
          prod   <= '0;
          mcnt   <= '0;
          state  <= B_MUL2;
        end
        B_ACC: begin
          if (tsel) begin
            coef[ci] <= coef_new;
            acc      <= '0;
            tsel     <= 1'b0;
            if (ci == CI_LAST) state <= B_IDLE;
            else begin
              ci    <= ci + 1'b1;
              state <= B_LOAD1;
            end
          end else begin
            acc   <= acc_sum;
            tsel  <= 1'b1;
            state <= B_LOAD1;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !busy && !rebuild |=> $stable(coef[0]) && $stable(coef[4]) && $stable(coef[8]))
    else $error("coefficients changed while builder idle");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    rebuild |=> state == B_ANG && ang_sel == 2'd0)
    else $error("rebuild request did not restart at yaw");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == B_MUL1 || state == B_MUL2) |-> mcnt <= MUL_LAST)
    else $error("multiplier step count overran");

endmodule
`default_nettype wire

// ===== src/ima_datapath.sv =====
// Four-stage sample path: gyro scaling, matrix products, row sums, round
// and saturate. Depends on ima_pkg and ima_chan_if.
`timescale 1ns / 1ps
`default_nettype none
module ima_datapath import ima_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        hold,
  input  coef_t       coef [NCOEF],
  input  logic [15:0] scale [3],
  ima_chan_if.sink    din,
  ima_chan_if.source  dout
);

  localparam int SW = (SAMPLE_BITS > FIELD_W) ? FIELD_W : SAMPLE_BITS;
  localparam logic signed [52:0] G_HI = 53'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [35:0] A_HI = 36'((64'sd1 <<< (SW - 1)) - 64'sd1);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic signed [15:0] gin [3];
  logic signed [15:0] ain [3];
  logic signed [32:0] g1 [3];
  logic signed [15:0] a1 [3];
  logic signed [50:0] pg [NCOEF];
  logic signed [33:0] pa [NCOEF];
  logic signed [52:0] sg [3];
  logic signed [35:0] sa [3];
  logic signed [52:0] rg [3];
  logic signed [35:0] ra [3];
  logic signed [15:0] og [3];
  logic signed [15:0] oa [3];
  sample_out_t        oq;

  assign en4 = !v4 || dout.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign din.ready = en1 && !hold;

  // keep the low SW bits of each field, sign extended
  always_comb begin
    gin[0] = 16'($signed(din.data.gyro_x_in[SW-1:0]));
    gin[1] = 16'($signed(din.data.gyro_y_in[SW-1:0]));
    gin[2] = 16'($signed(din.data.gyro_z_in[SW-1:0]));
    ain[0] = 16'($signed(din.data.accel_x_in[SW-1:0]));
    ain[1] = 16'($signed(din.data.accel_y_in[SW-1:0]));
    ain[2] = 16'($signed(din.data.accel_z_in[SW-1:0]));
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rg[r] = (sg[r] + 53'sd536870912) >>> 30;
      ra[r] = (sa[r] + 36'sd32768) >>> 16;
      if (rg[r] > G_HI) og[r] = 16'(G_HI);
      else if (rg[r] < -G_HI - 53'sd1) og[r] = 16'(-G_HI - 53'sd1);
      else og[r] = 16'(rg[r]);
      if (ra[r] > A_HI) oa[r] = 16'(A_HI);
      else if (ra[r] < -A_HI - 36'sd1) oa[r] = 16'(-A_HI - 36'sd1);
      else oa[r] = 16'(ra[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= din.valid && din.ready;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int j = 0; j < 3; j++) begin
        g1[j] <= 33'(gin[j]) * $signed({17'd0, scale[j]});
        a1[j] <= ain[j];
      end
    end
    if (en2) begin
      for (int k = 0; k < NCOEF; k++) begin
        pg[k] <= 51'(coef[k]) * 51'(g1[k % 3]);
        pa[k] <= 34'(coef[k]) * 34'(a1[k % 3]);
      end
    end
    if (en3) begin
      for (int r = 0; r < 3; r++) begin
        sg[r] <= 53'(pg[3*r]) + 53'(pg[3*r+1]) + 53'(pg[3*r+2]);
        sa[r] <= 36'(pa[3*r]) + 36'(pa[3*r+1]) + 36'(pa[3*r+2]);
      end
    end
    if (en4) begin
      oq.gyro_x_out  <= og[0];
      oq.gyro_y_out  <= og[1];
      oq.gyro_z_out  <= og[2];
      oq.accel_x_out <= oa[0];
      oq.accel_y_out <= oa[1];
      oq.accel_z_out <= oa[2];
    end
  end

  assign dout.valid = v4;
  assign dout.data  = oq;

  a_enter: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(din.valid && din.ready) |-> v1)
    else $error("accepted word missing from first stage");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !en2 |=> v1 && $stable(g1[0]) && $stable(a1[2]))
    else $error("first stage lost its word under stall");

  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !en4 |=> v3 && $stable(sg[0]) && $stable(sa[2]))
    else $error("sum stage lost its word under stall");

endmodule
`default_nettype wire

// ===== src/imu_mount_alignment_correction.sv =====
// An accepted input word passes the four registered datapath stages to the result word.
// Throughput: one word per cycle while dout is ready and no rebuild runs; the four-stage product/sum path sets it.
// Reset (and any angle register write) rebuilds the matrix on the shared
// CORDIC and shift-add multiplier, with input ready held low meanwhile.
// Registers reset to zero angles and unit gyro scales.
`timescale 1ns / 1ps
`default_nettype none
module imu_mount_alignment_correction import ima_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ima_chan_if.sink   din,
  ima_chan_if.source dout,
  ima_chan_if.sink   cfg
);

  logic signed [15:0] yaw, pitch, roll;
  logic [15:0]        scale [3];
  logic               rebuild;
  logic               busy;
  coef_t              coef [NCOEF];

  assign cfg.ready = 1'b1;
  assign rebuild = cfg.valid && (cfg.data.addr == REG_YAW || cfg.data.addr == REG_PITCH ||
                                 cfg.data.addr == REG_ROLL);

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw      <= '0;
      pitch    <= '0;
      roll     <= '0;
      scale[0] <= 16'd16384;
      scale[1] <= 16'd16384;
      scale[2] <= 16'd16384;
    end else if (cfg.valid) begin
      case (cfg.data.addr)
        REG_YAW:     yaw      <= $signed(cfg.data.wdata);
        REG_PITCH:   pitch    <= $signed(cfg.data.wdata);
        REG_ROLL:    roll     <= $signed(cfg.data.wdata);
        REG_SCALE_X: scale[0] <= cfg.data.wdata;
        REG_SCALE_Y: scale[1] <= cfg.data.wdata;
        REG_SCALE_Z: scale[2] <= cfg.data.wdata;
        default: ;
      endcase
    end
  end

  ima_coef_build #(.CORDIC_STEPS(CORDIC_STEPS)) u_build (
    .clk     (clk),
    .rst     (rst),
    .rebuild (rebuild),
    .yaw     (yaw),
    .pitch   (pitch),
    .roll    (roll),
    .busy    (busy),
    .coef    (coef)
  );

  ima_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_path (
    .clk   (clk),
    .rst   (rst),
    .hold  (busy),
    .coef  (coef),
    .scale (scale),
    .din   (din),
    .dout  (dout)
  );

endmodule
`default_nettype wire
